>>> hdl/mwps_pkg.sv
// mwps_pkg: shared constants, datapath command/status types for the
// pseudoforest sum block. No dependencies.
`default_nettype none

package mwps_pkg;

    localparam int ROW_W   = 9;
    localparam int COL_W   = 9;
    localparam int WIN_W   = 32;
    localparam int TOTAL_W = 42;

    localparam int DEF_MAX_CARDS   = 1024;
    localparam int DEF_MAX_ROWS    = 512;
    localparam int DEF_MAX_COLS    = 512;
    localparam int DEF_WEIGHT_BITS = 32;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_CLR,
        OP_LOAD,
        OP_SORT_INIT,
        OP_MSTART,
        OP_RDA,
        OP_CAPA,
        OP_RDB,
        OP_CAPB,
        OP_SEL,
        OP_NPAIR,
        OP_NPASS,
        OP_URD,
        OP_UCAP,
        OP_FSTART,
        OP_FRD,
        OP_FCHK,
        OP_CRD,
        OP_CCHK,
        OP_JOIN,
        OP_EMIT
    } t_dp_op;

    typedef enum logic [1:0] {
        FS_COL,
        FS_ROW,
        FS_SENT
    } t_fsel;

    typedef struct packed {
        t_dp_op op;
        t_fsel  fsel;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_last;
        logic take_a;
        logic pair_done;
        logic base_end;
        logic sort_done;
        logic uf_done;
        logic f_is_root;
        logic c_done;
        logic a_eq_b;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hdl/mwps_ram.sv
// mwps_ram: generic single write, single read RAM with registered read.
// No dependencies.
`default_nettype none

module mwps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/mwps_dp.sv
// mwps_dp: datapath - card store (ping-pong merge buffers), parent-link
// memory, merge/find registers and the running total. Uses mwps_pkg, mwps_ram.
`default_nettype none

module mwps_dp
    import mwps_pkg::*;
#(
    parameter int MAX_CARDS   = DEF_MAX_CARDS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    input  wire logic               i_in_valid,
    input  wire logic [ROW_W-1:0]   i_row,
    input  wire logic [COL_W-1:0]   i_column,
    input  wire logic [WIN_W-1:0]   i_weight,
    input  wire logic               i_last_card,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [TOTAL_W-1:0]      o_total
);

    localparam int CW    = ROW_W + COL_W + WEIGHT_BITS;
    localparam int AW    = (MAX_CARDS > 1) ? $clog2(MAX_CARDS) : 1;
    localparam int NW    = $clog2(MAX_CARDS + 1);
    localparam int PW    = NW + 2;
    localparam int VERTS = MAX_ROWS + MAX_COLS + 1;
    localparam int VW    = $clog2(VERTS);

    // control registers
    logic [NW-1:0]      r_n, r_i;
    logic [TOTAL_W-1:0] r_total;
    logic               r_out_valid;
    logic [VW-1:0]      r_clr;
    // payload registers
    logic [TOTAL_W-1:0] r_out_total;
    logic [PW-1:0]      r_w, r_base, r_l, r_lend, r_r, r_rend, r_o;
    logic               r_src;
    logic [CW-1:0]      r_ra, r_rb, r_card;
    logic [VW-1:0]      r_cur, r_start, r_top, r_a, r_b, r_s;

    logic [CW-1:0] rd_a, rd_b, c_rdata, c_wdata;
    logic [AW-1:0] c_raddr, c_waddr;
    logic          we_a, we_b, load_we, sel_we;
    logic [VW-1:0] p_rdata, p_waddr, p_wdata, f_vert, col_v, row_v, sent_v;
    logic          p_we, join_add;
    logic [PW-1:0] n_ext, sum_w, sum_2w, lend_n, rend_n;
    logic          a_ok, b_ok, take_a, row_ok, col_ok;

    assign n_ext  = PW'(r_n);
    assign a_ok   = r_l < r_lend;
    assign b_ok   = r_r < r_rend;
    assign take_a = a_ok && (!b_ok ||
                    r_ra[WEIGHT_BITS-1:0] >= r_rb[WEIGHT_BITS-1:0]);
    assign sum_w  = r_base + r_w;
    assign sum_2w = r_base + (r_w << 1);
    assign lend_n = (sum_w < n_ext) ? sum_w : n_ext;
    assign rend_n = (sum_2w < n_ext) ? sum_2w : n_ext;

    assign row_ok  = 32'(i_row) < 32'(MAX_ROWS);
    assign col_ok  = 32'(i_column) < 32'(MAX_COLS);
    assign load_we = (i_cmd.op == OP_LOAD) && i_in_valid && row_ok && col_ok
                     && (r_n < NW'(MAX_CARDS));
    assign sel_we  = (i_cmd.op == OP_SEL) && (a_ok || b_ok);
    // merge writes go to the buffer that is not the source
    assign we_a    = load_we || (sel_we && r_src);
    assign we_b    = sel_we && !r_src;
    assign c_rdata = r_src ? rd_b : rd_a;

    always_comb begin
        case (i_cmd.op)
            OP_RDB:  c_raddr = r_r[AW-1:0];
            OP_URD:  c_raddr = r_i[AW-1:0];
            default: c_raddr = r_l[AW-1:0];
        endcase
        if (i_cmd.op == OP_LOAD) begin
            c_waddr = r_n[AW-1:0];
            c_wdata = {i_row, i_column, WEIGHT_BITS'(i_weight)};
        end else begin
            c_waddr = r_o[AW-1:0];
            c_wdata = take_a ? r_ra : r_rb;
        end
    end

    mwps_ram #(.WIDTH(CW), .DEPTH(MAX_CARDS)) u_card_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (rd_a)
    );

    mwps_ram #(.WIDTH(CW), .DEPTH(MAX_CARDS)) u_card_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (rd_b)
    );

    // vertex numbering: columns first, rows after, sentinel last
    assign col_v  = VW'(r_card[WEIGHT_BITS +: COL_W]);
    assign row_v  = VW'(MAX_COLS) + VW'(r_card[WEIGHT_BITS+COL_W +: ROW_W]);
    assign sent_v = VW'(MAX_ROWS + MAX_COLS);

    always_comb begin
        case (i_cmd.fsel)
            FS_COL:  f_vert = col_v;
            FS_ROW:  f_vert = row_v;
            default: f_vert = sent_v;
        endcase
    end

    assign join_add = (r_a != r_b) || (r_a != r_s);

    always_comb begin
        p_we    = 1'b0;
        p_waddr = r_cur;
        p_wdata = r_top;
        case (i_cmd.op)
            OP_CLR: begin
                p_we    = 1'b1;
                p_waddr = r_clr;
                p_wdata = r_clr;
            end
            OP_CCHK: begin
                p_we = (p_rdata != r_top);
            end
            OP_JOIN: begin
                p_we    = join_add;
                p_waddr = r_a;
                p_wdata = (r_a != r_b) ? r_b : r_s;
            end
            default: begin
                p_we = 1'b0;
            end
        endcase
    end

    mwps_ram #(.WIDTH(VW), .DEPTH(VERTS)) u_parent (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (r_cur),
        .o_rdata (p_rdata)
    );

    always_comb begin
        o_stat.clr_last  = (r_clr == VW'(VERTS - 1));
        o_stat.in_last   = i_in_valid && i_last_card;
        o_stat.take_a    = take_a;
        o_stat.pair_done = !a_ok && !b_ok;
        o_stat.base_end  = r_base >= n_ext;
        o_stat.sort_done = r_w >= n_ext;
        o_stat.uf_done   = r_i >= r_n;
        o_stat.f_is_root = (p_rdata == r_cur);
        o_stat.c_done    = (p_rdata == r_top);
        o_stat.a_eq_b    = (r_a == r_b);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_i         <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_clr       <= '0;
        end else begin
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                OP_LOAD: begin
                    if (load_we) begin
                        r_n <= r_n + 1'b1;
                    end
                end
                OP_SORT_INIT: begin
                    r_i <= '0;
                end
                OP_JOIN: begin
                    r_i <= r_i + 1'b1;
                    if (join_add) begin
                        r_total <= r_total + TOTAL_W'(r_card[WEIGHT_BITS-1:0]);
                    end
                end
                OP_EMIT: begin
                    r_n         <= '0;
                    r_total     <= '0;
                    r_clr       <= '0;
                end
                default: begin
                    r_clr <= r_clr;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_SORT_INIT: begin
                r_w    <= PW'(1);
                r_base <= '0;
                r_src  <= 1'b0;
            end
            OP_MSTART: begin
                r_l    <= r_base;
                r_lend <= lend_n;
                r_r    <= lend_n;
                r_rend <= rend_n;
                r_o    <= r_base;
            end
            OP_CAPA: begin
                r_ra <= c_rdata;
            end
            OP_CAPB: begin
                r_rb <= c_rdata;
            end
            OP_SEL: begin
                if (take_a) begin
                    r_l <= r_l + 1'b1;
                end else if (b_ok) begin
                    r_r <= r_r + 1'b1;
                end
                r_o <= r_o + 1'b1;
            end
            OP_NPAIR: begin
                r_base <= sum_2w;
            end
            OP_NPASS: begin
                r_w    <= r_w << 1;
                r_base <= '0;
                r_src  <= !r_src;
            end
            OP_UCAP: begin
                r_card <= c_rdata;
            end
            OP_FSTART: begin
                r_cur   <= f_vert;
                r_start <= f_vert;
            end
            OP_FCHK: begin
                if (p_rdata == r_cur) begin
                    r_top <= r_cur;
                    r_cur <= r_start;
                end else begin
                    r_cur <= p_rdata;
                end
            end
            OP_CCHK: begin
                if (p_rdata != r_top) begin
                    r_cur <= p_rdata;
                end else begin
                    case (i_cmd.fsel)
                        FS_COL:  r_a <= r_top;
                        FS_ROW:  r_b <= r_top;
                        default: r_s <= r_top;
                    endcase
                end
            end
            OP_EMIT: begin
                r_out_total <= r_total;
            end
            default: begin
                r_src <= r_src;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_total     = r_out_total;

endmodule

`default_nettype wire

>>> hdl/mwps_ctrl.sv
// mwps_ctrl: sequencer for clear, load, merge sort, union-find and emit phases.
// Drives mwps_dp through t_dp_cmd / t_dp_stat from mwps_pkg.
`default_nettype none

module mwps_ctrl
    import mwps_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_in_ready
);

    typedef enum logic [4:0] {
        S_CLEAR, S_LOAD, S_SINIT, S_WCHK, S_MSTART,
        S_IA_RD, S_IA_CAP, S_IB_RD, S_IB_CAP, S_SEL,
        S_RA, S_CA, S_RB, S_CB, S_NPAIR, S_PCHK, S_NPASS,
        S_UCHK, S_URD, S_UCAP, S_FS, S_FRD, S_FCHK, S_CRD, S_CCHK,
        S_AB, S_JOIN, S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_fsel  r_fsel, n_fsel;

    always_comb begin
        n_state = r_state;
        n_fsel  = r_fsel;
        case (r_state)
            S_CLEAR:  if (i_stat.clr_last) n_state = S_LOAD;
            S_LOAD:   if (i_stat.in_last) n_state = S_SINIT;
            S_SINIT:  n_state = S_WCHK;
            S_WCHK:   n_state = i_stat.sort_done ? S_UCHK : S_MSTART;
            S_MSTART: n_state = S_IA_RD;
            S_IA_RD:  n_state = S_IA_CAP;
            S_IA_CAP: n_state = S_IB_RD;
            S_IB_RD:  n_state = S_IB_CAP;
            S_IB_CAP: n_state = S_SEL;
            S_SEL: begin
                if (i_stat.pair_done) begin
                    n_state = S_NPAIR;
                end else if (i_stat.take_a) begin
                    n_state = S_RA;
                end else begin
                    n_state = S_RB;
                end
            end
            S_RA:     n_state = S_CA;
            S_CA:     n_state = S_SEL;
            S_RB:     n_state = S_CB;
            S_CB:     n_state = S_SEL;
            S_NPAIR:  n_state = S_PCHK;
            S_PCHK:   n_state = i_stat.base_end ? S_NPASS : S_MSTART;
            S_NPASS:  n_state = S_WCHK;
            S_UCHK:   n_state = i_stat.uf_done ? S_EMIT : S_URD;
            S_URD:    n_state = S_UCAP;
            S_UCAP: begin
                n_state = S_FS;
                n_fsel  = FS_COL;
            end
            S_FS:     n_state = S_FRD;
            S_FRD:    n_state = S_FCHK;
            S_FCHK:   n_state = i_stat.f_is_root ? S_CRD : S_FRD;
            S_CRD:    n_state = S_CCHK;
            S_CCHK: begin
                if (!i_stat.c_done) begin
                    n_state = S_CRD;
                end else begin
                    case (r_fsel)
                        FS_COL: begin
                            n_state = S_FS;
                            n_fsel  = FS_ROW;
                        end
                        FS_ROW:  n_state = S_AB;
                        default: n_state = S_JOIN;
                    endcase
                end
            end
            S_AB: begin
                if (i_stat.a_eq_b) begin
                    n_state = S_FS;
                    n_fsel  = FS_SENT;
                end else begin
                    n_state = S_JOIN;
                end
            end
            S_JOIN:   n_state = S_UCHK;
            S_EMIT:   if (i_stat.out_free) n_state = S_CLEAR;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd.fsel = r_fsel;
        case (r_state)
            S_CLEAR:           o_cmd.op = OP_CLR;
            S_LOAD:            o_cmd.op = OP_LOAD;
            S_SINIT:           o_cmd.op = OP_SORT_INIT;
            S_MSTART:          o_cmd.op = OP_MSTART;
            S_IA_RD, S_RA:     o_cmd.op = OP_RDA;
            S_IA_CAP, S_CA:    o_cmd.op = OP_CAPA;
            S_IB_RD, S_RB:     o_cmd.op = OP_RDB;
            S_IB_CAP, S_CB:    o_cmd.op = OP_CAPB;
            S_SEL:             o_cmd.op = OP_SEL;
            S_NPAIR:           o_cmd.op = OP_NPAIR;
            S_NPASS:           o_cmd.op = OP_NPASS;
            S_URD:             o_cmd.op = OP_URD;
            S_UCAP:            o_cmd.op = OP_UCAP;
            S_FS:              o_cmd.op = OP_FSTART;
            S_FRD:             o_cmd.op = OP_FRD;
            S_FCHK:            o_cmd.op = OP_FCHK;
            S_CRD:             o_cmd.op = OP_CRD;
            S_CCHK:            o_cmd.op = OP_CCHK;
            S_JOIN:            o_cmd.op = OP_JOIN;
            S_EMIT:            o_cmd.op = i_stat.out_free ? OP_EMIT : OP_IDLE;
            default:           o_cmd.op = OP_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_fsel  <= FS_COL;
        end else begin
            r_state <= n_state;
            r_fsel  <= n_fsel;
        end
    end

endmodule

`default_nettype wire

>>> hdl/max_weight_pseudoforest_sum.sv
// max_weight_pseudoforest_sum: top level, controller plus datapath.
// Uses mwps_pkg, mwps_ctrl, mwps_dp (and mwps_ram below it).
//
// Usage
//   Input channel (i_in_valid / o_in_ready): one card per transfer, fields
//   i_row, i_column, i_weight, i_last_card. Cards load at one per cycle while ready is high.
//   Cards with row or column out of range, or beyond MAX_CARDS, are dropped;
//   their last_card flag still counts.
//   A transfer with i_last_card set closes the set: the block drops ready,
//   merge-sorts the stored cards by descending weight, then walks them through
//   union-find (each component allowed one cycle, tracked via a sentinel
//   vertex) and adds up the accepted weights.
//   Output channel (o_out_valid / i_out_ready): one transfer of o_total
//   (modulo 2^42) per set, held in an output register until taken.
// Sort and union-find
//   Sort: ceil(log2 n) merge passes, bound by the single read port of the
//   card buffers (one head refetch per output). Union-find: each card
//   takes a find on its column and row vertex, plus one on the sentinel
//   when both ends already share a root; each link walked is a read of the
//   parent memory, and path compression keeps the walks short.
// Reset and clearing
//   After reset and after each result the parent memory is cleared, one
//   vertex per cycle over all MAX_ROWS+MAX_COLS+1 vertices (1025 by default), ready low.
//   A stalled receiver holds the result; the next result waits for the
//   previous transfer, while the clear and the next load go ahead meanwhile.
`default_nettype none

module max_weight_pseudoforest_sum
    import mwps_pkg::*;
#(
    parameter int MAX_CARDS   = DEF_MAX_CARDS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [ROW_W-1:0]   i_row,
    input  wire logic [COL_W-1:0]   i_column,
    input  wire logic [WIN_W-1:0]   i_weight,
    input  wire logic               i_last_card,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [TOTAL_W-1:0]      o_total
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mwps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    mwps_dp #(
        .MAX_CARDS   (MAX_CARDS),
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_valid  (i_in_valid),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_weight    (i_weight),
        .i_last_card (i_last_card),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_total     (o_total)
    );

    // closing card: block goes busy next cycle
    a_last_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_card) |=> !o_in_ready)
        else $error("ready still high after closing card");

    // a new result never overwrites one still waiting
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_EMIT && o_out_valid) |-> i_out_ready)
        else $error("result overwritten before transfer");

    // emit always presents a result next cycle
    a_emit_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_EMIT) |=> o_out_valid)
        else $error("no result after emit");

endmodule

`default_nettype wire
